@@ src/ascii_duty_beep_command_parser_defines.svh @@
// assertion macros used by the checker file
`ifndef ASCII_DUTY_BEEP_COMMAND_PARSER_DEFINES_SVH
`define ASCII_DUTY_BEEP_COMMAND_PARSER_DEFINES_SVH

// a condition that must hold whenever the antecedent holds
`define ADBCP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("adbcp: implication failed");

// a signal that must hold its value over a stalled cycle
`define ADBCP_ASSERT_HOLD(lbl, vld, rdy, sig) \
   lbl: assert property (@(posedge clock) disable iff (reset) ((vld) && !(rdy)) |=> \
      $stable(sig)) else $error("adbcp: value changed while stalled");

`endif

@@ src/adbcp_pkg.sv @@
`timescale 1ns / 1ps

package adbcp_pkg;

   // packet length limit and counter width
   localparam int BUFFER_BYTES = 64;
   localparam int COUNT_W      = 8;

   localparam logic [7:0] TERM_RESET = 8'd35;

   // characters the matchers and tokenizer look for
   localparam logic [7:0] CHAR_D     = 8'h64;
   localparam logic [7:0] CHAR_U     = 8'h75;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CHAR_Y     = 8'h79;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_E     = 8'h65;
   localparam logic [7:0] CHAR_P     = 8'h70;
   localparam logic [7:0] CHAR_O     = 8'h6f;
   localparam logic [7:0] CHAR_N     = 8'h6e;
   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] CHAR_EQ    = 8'h3d;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [19:0] SAT_MAX = 20'd65535;

   // tokenizer position within the '=' separated packet
   typedef enum logic [4:0] {
      TOK_BEFORE  = 5'b00001,
      TOK_FIRST   = 5'b00010,
      TOK_BETWEEN = 5'b00100,
      TOK_SECOND  = 5'b01000,
      TOK_AFTER   = 5'b10000
   } token_phase_type;

   // number decoder position
   typedef enum logic [2:0] {
      NUM_SKIP   = 3'b001,
      NUM_DIGITS = 3'b010,
      NUM_DONE   = 3'b100
   } number_phase_type;

   // one packet result, duty_update in the lowest bit
   typedef struct packed {
      logic        ended_by_length;
      logic        beep_off_seen;
      logic        beep_on_seen;
      logic        beep_level;
      logic [15:0] duty_value;
      logic        duty_update;
   } result_type;

   localparam int RESULT_W = $bits(result_type);
   localparam int RSP_W    = ((RESULT_W + 7) / 8) * 8;

   // letters of "duty"
   function automatic logic [7:0] duty_char(input logic [2:0] p);
      logic [7:0] c;
      unique case (p)
         3'd0:    c = CHAR_D;
         3'd1:    c = CHAR_U;
         3'd2:    c = CHAR_T;
         3'd3:    c = CHAR_Y;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   // letters of "beep=o"
   function automatic logic [7:0] beep_char(input logic [3:0] p);
      logic [7:0] c;
      unique case (p)
         4'd0:    c = CHAR_B;
         4'd1:    c = CHAR_E;
         4'd2:    c = CHAR_E;
         4'd3:    c = CHAR_P;
         4'd4:    c = CHAR_EQ;
         4'd5:    c = CHAR_O;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

endpackage

@@ src/adbcp_parser_core.sv @@
`timescale 1ns / 1ps

module adbcp_parser_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            terminator,
   output logic                  close,
   output adbcp_pkg::result_type result
);

   // packet state
   logic [adbcp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                          ended_ff, ended_in;
   logic [2:0]                    dprog_ff, dprog_in;
   logic [3:0]                    bprog_ff, bprog_in;
   logic                          fduty_ff, fduty_in;
   logic                          fon_ff, fon_in;
   logic                          foff_ff, foff_in;
   adbcp_pkg::token_phase_type    tok_ff, tok_in;
   adbcp_pkg::number_phase_type   num_ff, num_in;
   logic                          neg_ff, neg_in;
   logic [15:0]                   acc_ff, acc_in;
   logic                          beep_ff;

   logic        active, is_eq, is_digit, is_space, is_sign, restart, feed;
   logic [19:0] prod;
   logic        upd, by_term, by_len, level;

   // character classes
   assign active   = !ended_ff && (rx_byte != adbcp_pkg::CHAR_NUL);
   assign is_eq    = (rx_byte == adbcp_pkg::CHAR_EQ);
   assign is_digit = (rx_byte >= adbcp_pkg::CHAR_ZERO) && (rx_byte <= adbcp_pkg::CHAR_NINE);
   assign is_space = (rx_byte == adbcp_pkg::CHAR_SPACE) ||
                     ((rx_byte >= adbcp_pkg::CHAR_TAB) && (rx_byte <= adbcp_pkg::CHAR_CR));
   assign is_sign  = (rx_byte == adbcp_pkg::CHAR_PLUS) || (rx_byte == adbcp_pkg::CHAR_MINUS);
   assign restart  = (rx_byte == adbcp_pkg::CHAR_B);

   // accumulator times ten plus the new digit
   assign prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                 {16'd0, rx_byte[3:0] - adbcp_pkg::CHAR_ZERO[3:0]};

   // word matchers
   always_comb begin
      dprog_in = dprog_ff;
      bprog_in = bprog_ff;
      fduty_in = fduty_ff;
      fon_in   = fon_ff;
      foff_in  = foff_ff;
      ended_in = ended_ff;
      if (!ended_ff && (rx_byte == adbcp_pkg::CHAR_NUL)) begin
         ended_in = 1'b1;
      end
      if (active) begin
         if ((dprog_ff < 3'd4) && (adbcp_pkg::duty_char(dprog_ff) == rx_byte)) begin
            if (dprog_ff == 3'd3) begin
               fduty_in = 1'b1;
               dprog_in = 3'd0;
            end else begin
               dprog_in = dprog_ff + 3'd1;
            end
         end else begin
            dprog_in = {2'b00, rx_byte == adbcp_pkg::CHAR_D};
         end
         if (bprog_ff < 4'd6) begin
            bprog_in = (adbcp_pkg::beep_char(bprog_ff) == rx_byte) ? bprog_ff + 4'd1
                                                                   : {3'b000, restart};
         end else if (bprog_ff == 4'd6) begin
            if (rx_byte == adbcp_pkg::CHAR_N) begin
               fon_in   = 1'b1;
               bprog_in = 4'd0;
            end else if (rx_byte == adbcp_pkg::CHAR_F) begin
               bprog_in = 4'd7;
            end else begin
               bprog_in = {3'b000, restart};
            end
         end else begin
            if (rx_byte == adbcp_pkg::CHAR_F) begin
               foff_in  = 1'b1;
               bprog_in = 4'd0;
            end else begin
               bprog_in = {3'b000, restart};
            end
         end
      end
   end

   // tokenizer and number decoder
   always_comb begin
      logic rest_done;
      tok_in    = tok_ff;
      num_in    = num_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      feed      = 1'b0;
      rest_done = 1'b0;
      if (active) begin
         unique case (tok_ff)
            adbcp_pkg::TOK_BEFORE:  if (!is_eq) tok_in = adbcp_pkg::TOK_FIRST;
            adbcp_pkg::TOK_FIRST:   if (is_eq) tok_in = adbcp_pkg::TOK_BETWEEN;
            adbcp_pkg::TOK_BETWEEN: if (!is_eq) begin
               tok_in = adbcp_pkg::TOK_SECOND;
               feed   = 1'b1;
            end
            adbcp_pkg::TOK_SECOND: if (is_eq) begin
               tok_in = adbcp_pkg::TOK_AFTER;
            end else begin
               feed = 1'b1;
            end
            default: ;
         endcase
      end
      if (feed) begin
         if (num_ff == adbcp_pkg::NUM_SKIP) begin
            if (is_space) begin
               rest_done = 1'b1;
            end else if (is_sign) begin
               neg_in    = (rx_byte == adbcp_pkg::CHAR_MINUS);
               num_in    = adbcp_pkg::NUM_DIGITS;
               rest_done = 1'b1;
            end else begin
               num_in = is_digit ? adbcp_pkg::NUM_DIGITS : adbcp_pkg::NUM_DONE;
            end
         end
         if (!rest_done && (num_in == adbcp_pkg::NUM_DIGITS)) begin
            if (is_digit) begin
               acc_in = (prod > adbcp_pkg::SAT_MAX) ? adbcp_pkg::SAT_MAX[15:0] : prod[15:0];
            end else begin
               num_in = adbcp_pkg::NUM_DONE;
            end
         end
      end
   end

   // packet close and result
   assign count_in = count_ff + {{(adbcp_pkg::COUNT_W-1){1'b0}}, 1'b1};
   assign by_term  = (rx_byte == terminator);
   assign by_len   = (count_in >= adbcp_pkg::COUNT_W'(adbcp_pkg::BUFFER_BYTES));
   assign close    = by_term || by_len;
   assign upd      = fduty_in && ((tok_in == adbcp_pkg::TOK_SECOND) ||
                                  (tok_in == adbcp_pkg::TOK_AFTER));
   assign level    = foff_in ? 1'b0 : (fon_in ? 1'b1 : beep_ff);

   always_comb begin
      result.duty_update     = upd;
      result.duty_value      = (upd && !neg_in) ? acc_in : 16'd0;
      result.beep_level      = level;
      result.beep_on_seen    = fon_in;
      result.beep_off_seen   = foff_in;
      result.ended_by_length = !by_term;
   end

   // state registers, cleared when a packet closes
   always_ff @(posedge clock) begin
      if (reset || (step && close)) begin
         count_ff <= '0;
         ended_ff <= 1'b0;
         dprog_ff <= 3'd0;
         bprog_ff <= 4'd0;
         fduty_ff <= 1'b0;
         fon_ff   <= 1'b0;
         foff_ff  <= 1'b0;
         tok_ff   <= adbcp_pkg::TOK_BEFORE;
         num_ff   <= adbcp_pkg::NUM_SKIP;
         neg_ff   <= 1'b0;
         acc_ff   <= 16'd0;
      end else if (step) begin
         count_ff <= count_in;
         ended_ff <= ended_in;
         dprog_ff <= dprog_in;
         bprog_ff <= bprog_in;
         fduty_ff <= fduty_in;
         fon_ff   <= fon_in;
         foff_ff  <= foff_in;
         tok_ff   <= tok_in;
         num_ff   <= num_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
      end
   end

   // beeper level persists across packets
   always_ff @(posedge clock) begin
      if (reset) begin
         beep_ff <= 1'b0;
      end else if (step && close) begin
         beep_ff <= level;
      end
   end

endmodule

@@ src/ascii_duty_beep_command_parser.sv @@
`timescale 1ns / 1ps
// ASCII duty and beeper command parser.
// req_ channel: one received serial byte per item in req_tdata[7:0].
// rsp_ channel: one item per closed packet with the decoded duty value and
// beeper state. A packet closes on the terminator byte (csr_wr_data written
// with csr_wr_en, reset value '#') or on the byte that fills the 64 byte buffer.
// A byte is registered on acceptance and parsed from the input register against
// the running match, token and number state; a closing byte pushes its result
// into a two-entry output queue.
// Throughput: one byte per cycle, set by the single parse stage, except that a
// closing byte waits while both queue entries are taken.
// A result reaches rsp_tvalid through the input register and the output queue.
// Reset: packet state cleared, beeper off, terminator back to '#', queue empty.
// Stall: while rsp_tready is low results wait in the queue; bytes that close
// no packet keep flowing, and a closing byte waits in the input register
// (req_tready low) only when both queue entries are taken.

module ascii_duty_beep_command_parser (
   input  logic                         clock,
   input  logic                         reset,
   // req_tdata: rx_byte[7:0]
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,
   // rsp_tdata: duty_update[0], duty_value[16:1], beep_level[17],
   // beep_on_seen[18], beep_off_seen[19], ended_by_length[20], zero[23:21]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [adbcp_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                         csr_wr_en,
   input  logic [7:0]                   csr_wr_data
);

   logic [7:0]            term_val_ff;
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  close, fire, push, pop;
   adbcp_pkg::result_type result;
   adbcp_pkg::result_type queue_mem [2];
   logic                  wr_ptr_ff, rd_ptr_ff;
   logic [1:0]            cnt_ff;

   // terminator register
   always_ff @(posedge clock) begin
      if (reset) begin
         term_val_ff <= adbcp_pkg::TERM_RESET;
      end else if (csr_wr_en) begin
         term_val_ff <= csr_wr_data;
      end
   end

   // input register
   assign fire        = in_valid_ff && (!close || (cnt_ff != 2'd2));
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // parse stage
   adbcp_parser_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (fire),
      .rx_byte    (in_byte_ff),
      .terminator (term_val_ff),
      .close      (close),
      .result     (result)
   );

   // output queue
   assign push = fire && close;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= result;
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {{(adbcp_pkg::RSP_W - adbcp_pkg::RESULT_W){1'b0}}, queue_mem[rd_ptr_ff]};

endmodule

@@ src/adbcp_checker.sv @@
`timescale 1ns / 1ps
`include "ascii_duty_beep_command_parser_defines.svh"

module adbcp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [adbcp_pkg::RSP_W-1:0] rsp_tdata
);

   // stalled results hold
   `ADBCP_ASSERT_HOLD(a_rsp_valid_hold, rsp_tvalid, rsp_tready, rsp_tvalid)
   `ADBCP_ASSERT_HOLD(a_rsp_data_hold, rsp_tvalid, rsp_tready, rsp_tdata)

   // padding bits stay zero
   `ADBCP_ASSERT_IMP(a_pad_zero, rsp_tvalid, rsp_tdata[23:21] == 3'b000)

   // beep=off wins over beep=on
   `ADBCP_ASSERT_IMP(a_off_wins, rsp_tvalid && rsp_tdata[19], !rsp_tdata[17])

   // no duty value without an update
   `ADBCP_ASSERT_IMP(a_duty_zero, rsp_tvalid && !rsp_tdata[0], rsp_tdata[16:1] == 16'd0)

endmodule

bind ascii_duty_beep_command_parser adbcp_checker u_adbcp_checker (.*);

@@ tb/sv/ascii_duty_beep_command_parser_test.sv @@
`timescale 1ns / 1ps

module ascii_duty_beep_command_parser_test;

   localparam int QUIET_CYCLES = 8;
   localparam int TAIL_CYCLES  = 12;
   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_AT      = 25;
   localparam int HOLD_CYCLES  = 300;
   localparam int REPORT_MAX   = 10;
   localparam int PHASE_BYTES  = 210;

   localparam logic [7:0]  CHAR_LF   = 8'h0a;
   localparam logic [31:0] DUTY_WORD = {adbcp_pkg::CHAR_Y, adbcp_pkg::CHAR_T,
                                        adbcp_pkg::CHAR_U, adbcp_pkg::CHAR_D};
   localparam logic [47:0] BEEP_WORD = {adbcp_pkg::CHAR_O, adbcp_pkg::CHAR_EQ,
                                        adbcp_pkg::CHAR_P, adbcp_pkg::CHAR_E,
                                        adbcp_pkg::CHAR_E, adbcp_pkg::CHAR_B};

   typedef enum logic [1:0] {
      ITEM_BYTE,
      ITEM_CFG,
      ITEM_DRAIN
   } feed_kind_type;

   typedef struct {
      feed_kind_type kind;
      logic [7:0]    value;
   } feed_item_type;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_tvalid  = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata   = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready  = 1'b0;
   logic [adbcp_pkg::RSP_W-1:0]   rsp_tdata;
   logic                          csr_wr_en   = 1'b0;
   logic [7:0]                    csr_wr_data = '0;

   feed_item_type         pending_items[$];
   adbcp_pkg::result_type packet_reports_due[$];

   // packet parse state of the predictor
   int                          pkt_len;
   bit                          pkt_nul;
   int                          duty_prog;
   int                          beep_prog;
   bit                          got_duty;
   bit                          got_on;
   bit                          got_off;
   adbcp_pkg::token_phase_type  tok;
   adbcp_pkg::number_phase_type num_ph;
   bit                          num_neg;
   int                          num_acc;
   bit                          beeper;
   logic [7:0]                  term_model;

   int         mismatch_count = 0;
   int         results_seen   = 0;
   int         byte_total     = 0;
   int         send_wait      = 0;
   int         recv_wait      = 0;
   int         hold_left      = 0;
   int         quiet          = 0;
   int         stall_cycles   = 0;
   bit         send_calm      = 1'b0;
   bit         recv_calm      = 1'b0;
   logic [7:0] term_plan      = adbcp_pkg::TERM_RESET;

   ascii_duty_beep_command_parser u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock and the single reset pulse
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_packet();
      pkt_len   = 0;
      pkt_nul   = 1'b0;
      duty_prog = 0;
      beep_prog = 0;
      got_duty  = 1'b0;
      got_on    = 1'b0;
      got_off   = 1'b0;
      tok       = adbcp_pkg::TOK_BEFORE;
      num_ph    = adbcp_pkg::NUM_SKIP;
      num_neg   = 1'b0;
      num_acc   = 0;
   endfunction

   function automatic void track_duty(input logic [7:0] c);
      int p;
      p = duty_prog;
      if (p < 4 && DUTY_WORD[8*p +: 8] == c) begin
         p++;
         if (p == 4) begin
            got_duty = 1'b1;
            p = 0;
         end
      end else begin
         p = (c == adbcp_pkg::CHAR_D) ? 1 : 0;
      end
      duty_prog = p;
   endfunction

   // progress 6 means "beep=o" seen, 7 means "beep=of"
   function automatic void track_beep(input logic [7:0] c);
      int p;
      int restart;
      p = beep_prog;
      restart = (c == adbcp_pkg::CHAR_B) ? 1 : 0;
      if (p < 6) begin
         p = (BEEP_WORD[8*p +: 8] == c) ? p + 1 : restart;
      end else if (p == 6) begin
         if (c == adbcp_pkg::CHAR_N) begin
            got_on = 1'b1;
            p = 0;
         end else if (c == adbcp_pkg::CHAR_F) begin
            p = 7;
         end else begin
            p = restart;
         end
      end else begin
         if (c == adbcp_pkg::CHAR_F) begin
            got_off = 1'b1;
            p = 0;
         end else begin
            p = restart;
         end
      end
      beep_prog = p;
   endfunction

   // atoi style: blanks, optional sign, digits, saturating
   function automatic void feed_digit(input logic [7:0] c);
      bit digit;
      bit blank;
      digit = (c >= adbcp_pkg::CHAR_ZERO && c <= adbcp_pkg::CHAR_NINE);
      blank = (c == adbcp_pkg::CHAR_SPACE) ||
              (c >= adbcp_pkg::CHAR_TAB && c <= adbcp_pkg::CHAR_CR);
      if (num_ph == adbcp_pkg::NUM_SKIP) begin
         if (blank) return;
         if (c == adbcp_pkg::CHAR_PLUS || c == adbcp_pkg::CHAR_MINUS) begin
            num_neg = (c == adbcp_pkg::CHAR_MINUS);
            num_ph  = adbcp_pkg::NUM_DIGITS;
            return;
         end
         num_ph = digit ? adbcp_pkg::NUM_DIGITS : adbcp_pkg::NUM_DONE;
      end
      if (num_ph == adbcp_pkg::NUM_DIGITS) begin
         if (digit) begin
            num_acc = num_acc * 10 + int'(c - adbcp_pkg::CHAR_ZERO);
            if (num_acc > int'(adbcp_pkg::SAT_MAX)) num_acc = int'(adbcp_pkg::SAT_MAX);
         end else begin
            num_ph = adbcp_pkg::NUM_DONE;
         end
      end
   endfunction

   // '=' separated tokens, only the second one is decoded
   function automatic void track_token(input logic [7:0] c);
      bit eq;
      eq = (c == adbcp_pkg::CHAR_EQ);
      case (tok)
         adbcp_pkg::TOK_BEFORE:  if (!eq) tok = adbcp_pkg::TOK_FIRST;
         adbcp_pkg::TOK_FIRST:   if (eq) tok = adbcp_pkg::TOK_BETWEEN;
         adbcp_pkg::TOK_BETWEEN: begin
            if (!eq) begin
               tok = adbcp_pkg::TOK_SECOND;
               feed_digit(c);
            end
         end
         adbcp_pkg::TOK_SECOND: begin
            if (eq) tok = adbcp_pkg::TOK_AFTER;
            else feed_digit(c);
         end
         default: ;
      endcase
   endfunction

   // one received byte; returns 1 with the packet report when it closes a packet
   function automatic bit parse_rx_byte(input logic [7:0] c,
                                        output adbcp_pkg::result_type r);
      bit by_term;
      bit by_len;
      bit upd;
      r = '0;
      pkt_len++;
      if (!pkt_nul) begin
         if (c == adbcp_pkg::CHAR_NUL) begin
            pkt_nul = 1'b1;
         end else begin
            track_duty(c);
            track_beep(c);
            track_token(c);
         end
      end
      by_term = (c == term_model);
      by_len  = (pkt_len >= adbcp_pkg::BUFFER_BYTES);
      if (!by_term && !by_len) return 1'b0;
      upd = got_duty && (tok == adbcp_pkg::TOK_SECOND || tok == adbcp_pkg::TOK_AFTER);
      if (got_on) beeper = 1'b1;
      if (got_off) beeper = 1'b0;
      r.duty_update     = upd;
      r.duty_value      = (upd && !num_neg) ? num_acc[15:0] : 16'd0;
      r.beep_level      = beeper;
      r.beep_on_seen    = got_on;
      r.beep_off_seen   = got_off;
      r.ended_by_length = !by_term;
      clear_packet();
      return 1'b1;
   endfunction

   // gap before the next item, with calm stretches of no idling
   function automatic int draw_gap(inout bit calm);
      if ($urandom_range(0, 63) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 4);
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : feed_proc
      logic                  nxt_valid;
      logic [7:0]            nxt_byte;
      logic                  nxt_wr;
      logic [7:0]            nxt_wdata;
      bit                    idle;
      feed_item_type         it;
      adbcp_pkg::result_type r;
      if (reset) begin
         clear_packet();
         beeper     = 1'b0;
         term_model = adbcp_pkg::TERM_RESET;
         quiet      = 0;
         send_wait  = 0;
         req_tvalid <= 1'b0;
         csr_wr_en  <= 1'b0;
      end else begin
         nxt_valid = req_tvalid;
         nxt_byte  = req_tdata;
         nxt_wr    = 1'b0;
         nxt_wdata = csr_wr_data;
         if (csr_wr_en) term_model = csr_wr_data;
         if (req_tvalid && req_tready) begin
            if (parse_rx_byte(req_tdata, r)) packet_reports_due.push_back(r);
            nxt_valid = 1'b0;
            quiet = 0;
         end else if (!req_tvalid) begin
            quiet++;
         end
         idle = (packet_reports_due.size() == 0) && (quiet >= QUIET_CYCLES);
         if (!nxt_valid) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_items.size() > 0) begin
               it = pending_items[0];
               case (it.kind)
                  ITEM_BYTE: begin
                     nxt_valid = 1'b1;
                     nxt_byte  = it.value;
                     void'(pending_items.pop_front());
                     send_wait = draw_gap(send_calm);
                  end
                  ITEM_CFG: begin
                     if (idle && !csr_wr_en) begin
                        nxt_wr    = 1'b1;
                        nxt_wdata = it.value;
                        void'(pending_items.pop_front());
                     end
                  end
                  default: begin
                     if (idle) void'(pending_items.pop_front());
                  end
               endcase
            end
         end
         req_tvalid  <= nxt_valid;
         req_tdata   <= nxt_byte;
         csr_wr_en   <= nxt_wr;
         csr_wr_data <= nxt_wdata;
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : check_proc
      adbcp_pkg::result_type got;
      adbcp_pkg::result_type want;
      bit                    bad;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[adbcp_pkg::RESULT_W-1:0];
            results_seen++;
            if (packet_reports_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display({"unexpected packet report: ",
                            "upd=%0b val=%0d lvl=%0b on=%0b off=%0b len=%0b"},
                           got.duty_update, got.duty_value, got.beep_level,
                           got.beep_on_seen, got.beep_off_seen, got.ended_by_length);
            end else begin
               want = packet_reports_due.pop_front();
               bad = (got.duty_update !== want.duty_update)
                  || (got.duty_value !== want.duty_value)
                  || (got.beep_level !== want.beep_level)
                  || (got.beep_on_seen !== want.beep_on_seen)
                  || (got.beep_off_seen !== want.beep_off_seen)
                  || (got.ended_by_length !== want.ended_by_length);
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX) begin
                     $display({"report %0d expected: ",
                               "upd=%0b val=%0d lvl=%0b on=%0b off=%0b len=%0b"},
                              results_seen, want.duty_update, want.duty_value,
                              want.beep_level, want.beep_on_seen, want.beep_off_seen,
                              want.ended_by_length);
                     $display({"report %0d actual:   ",
                               "upd=%0b val=%0d lvl=%0b on=%0b off=%0b len=%0b"},
                              results_seen, got.duty_update, got.duty_value,
                              got.beep_level, got.beep_on_seen, got.beep_off_seen,
                              got.ended_by_length);
                  end
               end
            end
            // one long hold-off so the output queue fills and the input stalls
            if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            else recv_wait = draw_gap(recv_calm);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("ascii_duty_beep_command_parser_test: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_byte(input logic [7:0] b);
      feed_item_type it;
      it.kind  = ITEM_BYTE;
      it.value = b;
      pending_items.push_back(it);
      byte_total++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic push_cfg(input logic [7:0] v);
      feed_item_type it;
      it.kind  = ITEM_CFG;
      it.value = v;
      pending_items.push_back(it);
      term_plan = v;
   endtask

   task automatic push_drain();
      feed_item_type it;
      it.kind  = ITEM_DRAIN;
      it.value = '0;
      pending_items.push_back(it);
   endtask

   task automatic push_blanks();
      int n;
      n = $urandom_range(0, 2);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0:       push_byte(adbcp_pkg::CHAR_TAB);
            1:       push_byte(adbcp_pkg::CHAR_CR);
            2:       push_byte(CHAR_LF);
            default: push_byte(adbcp_pkg::CHAR_SPACE);
         endcase
      end
   endtask

   task automatic push_number();
      int n;
      case ($urandom_range(0, 3))
         0:       push_byte(adbcp_pkg::CHAR_MINUS);
         1:       push_byte(adbcp_pkg::CHAR_PLUS);
         default: ;
      endcase
      n = $urandom_range(1, 6);
      repeat (n) push_byte(adbcp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic push_noise(input int lo, input int hi);
      int n;
      n = $urandom_range(lo, hi);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
   endtask

   // one random packet body, mostly well formed, then the terminator
   task automatic push_command();
      int kind;
      kind = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) push_text("x ");
      case (kind)
         0, 1, 2, 3: begin
            push_text("duty=");
            push_blanks();
            push_number();
            if ($urandom_range(0, 3) == 0) push_text("=ms");
            if ($urandom_range(0, 4) == 0) push_text(" beep=on");
         end
         4:  push_text("beep=on");
         5:  push_text("beep=off");
         6: begin
            if ($urandom_range(0, 1) == 0) push_text("beep=off beep=on");
            else push_text("beep=on,beep=off");
         end
         7:  push_text("duty");
         8: begin
            case ($urandom_range(0, 3))
               0:       push_text("dut=12");
               1:       push_text("beep=o");
               2:       push_text("bbeep=oof");
               default: push_text("ddutyy=beep=of");
            endcase
         end
         9:  push_noise(1, 12);
         10: begin
            push_text("duty=");
            push_number();
            push_byte(adbcp_pkg::CHAR_NUL);
            push_text("beep=on=9");
         end
         11: begin
            push_text("set=");
            push_number();
            push_text(" duty beep=off");
         end
         12: begin
            if ($urandom_range(0, 3) == 0) begin
               push_noise(adbcp_pkg::BUFFER_BYTES, adbcp_pkg::BUFFER_BYTES + 8);
            end else begin
               push_noise(1, 6);
            end
         end
         default: begin
            push_text("duty=");
         end
      endcase
      push_byte(term_plan);
   endtask

   initial begin : stim_proc
      logic [7:0] phase_terms[5];
      int         goal;

      // directed packets under the reset terminator
      push_text("duty=123#");
      push_text("duty= \t-42#");
      push_text("duty=+99999#");
      push_text("duty#");
      push_text("beep=on#");
      push_text("xyz=7#");
      push_text("beep=off#");
      push_text("beep=on beep=off#");
      push_text("beep=on#");
      push_text("duty=5");
      push_byte(adbcp_pkg::CHAR_NUL);
      push_text("beep=off#");
      push_text("bbeep=oof beep=obeep=off duty=1=2#");
      push_byte(8'hff);
      push_text("=65535#");
      repeat (adbcp_pkg::BUFFER_BYTES) push_byte("a");
      repeat (adbcp_pkg::BUFFER_BYTES - 1) push_byte("a");
      push_byte("#");
      push_text("duty=#");

      // random phases; the terminator changes between phases, back to '#' for the last
      phase_terms[0] = 8'h00;
      phase_terms[1] = 8'hff;
      phase_terms[2] = 8'($urandom_range(1, 254));
      phase_terms[3] = CHAR_LF;
      phase_terms[4] = adbcp_pkg::TERM_RESET;
      goal = byte_total;
      for (int ph = 0; ph <= 5; ph++) begin
         goal += PHASE_BYTES;
         while (byte_total < goal) begin
            push_command();
            if (ph == 0 && byte_total > goal - 130 && byte_total < goal - 110) push_drain();
         end
         if (ph < 5) push_cfg(phase_terms[ph]);
      end

      // wait for the queue and all packet reports, then a short tail
      while (pending_items.size() != 0 || req_tvalid || packet_reports_due.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("ascii_duty_beep_command_parser_test: PASS");
      end else begin
         $display("ascii_duty_beep_command_parser_test: FAIL");
      end
      $finish;
   end

endmodule
